// ===== hw/rtl/comment_strip_token_spacer_macros.svh =====
// assertion macros for the checker file css_check.sv
`ifndef COMMENT_STRIP_TOKEN_SPACER_MACROS_SVH
`define COMMENT_STRIP_TOKEN_SPACER_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/css_pkg.sv =====
// shared constants and character classes for the comment strip token spacer
package css_pkg;

	// most output beats one input byte can cause
	localparam int MaxResults = 4;

	// character codes
	localparam logic [7:0] CharNul   = 8'h00;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharNl    = 8'h0A;
	localparam logic [7:0] CharVt    = 8'h0B;
	localparam logic [7:0] CharFf    = 8'h0C;
	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharSp    = 8'h20;
	localparam logic [7:0] CharSlash = 8'h2F;

	// operator and punctuation characters that form delimiter runs
	function automatic logic is_delim(input logic [7:0] c);
		logic d;
		unique case (c)
			8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h28, 8'h29, 8'h7B, 8'h7D,
			8'h5B, 8'h5D, 8'h25, 8'h3F, 8'h3A, 8'h7C, 8'h26, 8'h2C, 8'h3B: d = 1'b1;
			default: d = 1'b0;
		endcase
		return d;
	endfunction

	// whitespace other than newline: space, tab, CR, VT and FF
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CharSp) || (c == CharTab) || (c == CharCr) ||
			(c == CharVt) || (c == CharFf);
	endfunction

endpackage

// ===== hw/rtl/comment_strip_token_spacer.sv =====
// top level: line respacer with comment removal, one text byte in, up to four chars out
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+---------------------------
//  text    | text_valid | text_stall | text_byte, end_of_input
//  char    | char_valid | char_stall | out_char, last_of_item
//
// a byte is scanned in the cycle it is accepted; its output beats leave from a
// four-entry result register starting the next cycle, one beat per cycle while char_stall is low
// a byte with at most one output beat keeps the rate at one byte per cycle while char_stall is low;
// a byte with more beats holds the text side until only its last beat is pending
// arst_n clears the scanner to the start state and empties the result register
// while the last pending beat is stalled, text_stall follows char_stall
module comment_strip_token_spacer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_input,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [7:0] out_char,
	output logic       last_of_item
);
	import css_pkg::*;

	localparam int CntW = $clog2(MaxResults + 1);
	localparam int IdxW = $clog2(MaxResults);

	typedef enum logic [2:0] {
		MODE_START,
		MODE_TOKEN,
		MODE_SPACE,
		MODE_DELIM,
		MODE_COMMENT
	} mode_t;

	mode_t           mode_q;
	logic            held_q;
	logic            has_text_q;
	logic [7:0]      res_char_s1 [MaxResults];
	logic [CntW-1:0] res_cnt_s1;

	logic            is_d;
	logic            is_w;
	logic            scan_en;
	logic            line_end;
	logic            emit_sp;
	logic            emit_c;
	logic            hold_set;
	logic            puts;
	mode_t           mode_scan;
	mode_t           mode_d;
	logic            held_d;
	logic            text_d;
	logic [7:0]      slot [MaxResults];
	logic [CntW-1:0] n;
	logic            accept;
	logic            take;

	// scanner: next state and the list of chars for this byte
	always_comb begin
		is_d      = is_delim(text_byte);
		is_w      = is_blank(text_byte);
		scan_en   = (text_byte != CharNl) && (text_byte != CharNul);
		line_end  = (text_byte == CharNl) || end_of_input;
		emit_sp   = 1'b0;
		emit_c    = 1'b0;
		hold_set  = 1'b0;
		mode_scan = mode_q;
		if (scan_en) begin
			unique case (mode_q)
				MODE_START, MODE_SPACE: begin
					if (text_byte == CharSlash) begin
						mode_scan = MODE_COMMENT;
					end else if (is_d) begin
						emit_c    = 1'b1;
						hold_set  = (mode_q == MODE_SPACE);
						mode_scan = MODE_DELIM;
					end else if (!is_w) begin
						emit_c    = 1'b1;
						mode_scan = MODE_TOKEN;
					end
				end
				MODE_TOKEN: begin
					if (text_byte == CharSlash) begin
						mode_scan = MODE_COMMENT;
					end else if (is_d) begin
						emit_sp = 1'b1;
						emit_c  = 1'b1;
					end else if (is_w) begin
						hold_set  = 1'b1;
						mode_scan = MODE_SPACE;
					end else begin
						emit_c = 1'b1;
					end
				end
				MODE_DELIM: begin
					if (is_d) begin
						emit_sp = 1'b1;
						emit_c  = 1'b1;
					end else if (is_w) begin
						mode_scan = MODE_SPACE;
					end else begin
						emit_c    = 1'b1;
						mode_scan = MODE_TOKEN;
					end
				end
				default: begin
					// comment: rest of line is dropped
				end
			endcase
		end
		puts = emit_sp | emit_c;

		// pack the chars in output order
		n = '0;
		for (int i = 0; i < MaxResults; i++) begin
			slot[i] = CharSp;
		end
		if (held_q && puts) begin
			slot[n[IdxW-1:0]] = CharSp;
			n = n + CntW'(1);
		end
		if (emit_sp) begin
			slot[n[IdxW-1:0]] = CharSp;
			n = n + CntW'(1);
		end
		if (emit_c) begin
			slot[n[IdxW-1:0]] = text_byte;
			n = n + CntW'(1);
		end

		held_d = hold_set | (held_q & ~puts);
		text_d = has_text_q | puts;
		mode_d = mode_scan;

		// line end drops the held space and closes a non-empty line
		if (line_end) begin
			if (text_d) begin
				slot[n[IdxW-1:0]] = CharNl;
				n = n + CntW'(1);
			end
			held_d = 1'b0;
			text_d = 1'b0;
			mode_d = MODE_START;
		end
	end

	// handshakes
	assign char_valid   = (res_cnt_s1 != '0);
	assign out_char     = res_char_s1[0];
	assign last_of_item = (res_cnt_s1 == CntW'(1));
	assign take         = char_valid & ~char_stall;
	assign text_stall   = (res_cnt_s1 > CntW'(1)) |
		((res_cnt_s1 == CntW'(1)) & char_stall);
	assign accept       = text_valid & ~text_stall;

	// scanner state and result register: load a new list or shift one beat out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_START;
			held_q     <= 1'b0;
			has_text_q <= 1'b0;
			res_cnt_s1 <= '0;
			for (int i = 0; i < MaxResults; i++) begin
				res_char_s1[i] <= CharSp;
			end
		end else begin
			if (accept) begin
				mode_q     <= mode_d;
				held_q     <= held_d;
				has_text_q <= text_d;
			end
			if (accept && (n != '0)) begin
				res_cnt_s1  <= n;
				res_char_s1 <= slot;
			end else if (take) begin
				res_cnt_s1 <= res_cnt_s1 - CntW'(1);
				for (int i = 0; i < MaxResults - 1; i++) begin
					res_char_s1[i] <= res_char_s1[i + 1];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/css_check.sv =====
// port-level assertion checker for the comment strip token spacer, with its bind
`include "comment_strip_token_spacer_macros.svh"

module css_check (
	input logic       clk,
	input logic       arst_n,
	input logic       text_stall,
	input logic       char_valid,
	input logic       char_stall,
	input logic [7:0] out_char,
	input logic       last_of_item
);
	import css_pkg::*;

	// a stalled output beat stays put
	`CSS_ASSERT_NEXT(a_char_hold, char_valid && char_stall, char_valid && $stable(out_char) && $stable(last_of_item), "stalled char beat changed")

	// input is held while more than one beat of an item is pending
	`CSS_ASSERT_NOW(a_burst_stall, char_valid && !last_of_item, text_stall, "byte accepted during multi-beat burst")

	// a newline always closes the beats of its byte
	`CSS_ASSERT_NOW(a_nl_last, char_valid && (out_char == CharNl), last_of_item, "newline not last beat")

	// a space never ends a byte's output, it always precedes text
	`CSS_ASSERT_NOW(a_sp_not_last, char_valid && (out_char == CharSp), !last_of_item, "trailing space emitted")

endmodule

bind comment_strip_token_spacer css_check u_css_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.text_stall   (text_stall),
	.char_valid   (char_valid),
	.char_stall   (char_stall),
	.out_char     (out_char),
	.last_of_item (last_of_item)
);

// ===== tb/sv/comment_strip_token_spacer_test.sv =====
// self-checking testbench for the comment strip token spacer
`timescale 1ns / 100ps

module comment_strip_token_spacer_test;
	import css_pkg::*;

	localparam int ResetCycles   = 11;
	localparam int RandomItems   = 400;
	localparam int StuckLimit    = 2000;
	localparam int DrainCycles   = 8;
	localparam int MaxShownFails = 10;

	typedef enum logic [2:0] {
		ModeStart,
		ModeToken,
		ModeSpace,
		ModeDelim,
		ModeComment
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	// tracks the respaced text expected from the bytes fed in so far
	class respace_scoreboard;
		scan_mode_t mode;
		bit         space_held;
		bit         line_text;
		char_beat_t pending_chars[$];
		int         fails;

		function new();
			mode       = ModeStart;
			space_held = 1'b0;
			line_text  = 1'b0;
			fails      = 0;
		endfunction

		function bit is_operator_char(logic [7:0] c);
			case (c)
				"+", "-", "*", "/", "=", "(", ")", "{", "}",
				"[", "]", "%", "?", ":", "|", "&", ",", ";": return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function bit is_spacing_char(logic [7:0] c);
			return c == CharSp || c == CharTab || c == CharCr || c == CharVt || c == CharFf;
		endfunction

		function void add_char(logic [7:0] c);
			pending_chars.push_back('{ch: c, last: 1'b0});
		endfunction

		// a held space goes out ahead of any text
		function void put_text(logic [7:0] c);
			if (space_held) begin
				add_char(CharSp);
				space_held = 1'b0;
			end
			add_char(c);
			line_text = 1'b1;
		endfunction

		function void close_line();
			space_held = 1'b0;
			if (line_text)
				add_char(CharNl);
			mode      = ModeStart;
			line_text = 1'b0;
		endfunction

		// input beat accepted: predict its output chars
		function void note_byte(logic [7:0] c, logic eoi);
			bit         delim_c;
			bit         blank_c;
			int         first;
			char_beat_t tail;
			first   = pending_chars.size();
			delim_c = is_operator_char(c);
			blank_c = is_spacing_char(c);
			if (c == CharNl) begin
				close_line();
			end else begin
				if (c != CharNul) begin
					case (mode)
						ModeStart, ModeSpace: begin
							if (c == CharSlash) begin
								mode = ModeComment;
							end else if (delim_c) begin
								put_text(c);
								if (mode == ModeSpace)
									space_held = 1'b1;
								mode = ModeDelim;
							end else if (!blank_c) begin
								put_text(c);
								mode = ModeToken;
							end
						end
						ModeToken: begin
							if (c == CharSlash) begin
								mode = ModeComment;
							end else if (delim_c) begin
								put_text(CharSp);
								put_text(c);
							end else if (blank_c) begin
								space_held = 1'b1;
								mode       = ModeSpace;
							end else begin
								put_text(c);
							end
						end
						ModeDelim: begin
							if (delim_c) begin
								put_text(CharSp);
								put_text(c);
							end else if (blank_c) begin
								mode = ModeSpace;
							end else begin
								put_text(c);
								mode = ModeToken;
							end
						end
						default: ;
					endcase
				end
				if (eoi)
					close_line();
			end
			// flag the final char caused by this byte
			if (pending_chars.size() > first) begin
				tail      = pending_chars.pop_back();
				tail.last = 1'b1;
				pending_chars.push_back(tail);
			end
		endfunction

		function void note_fail(string msg);
			fails++;
			if (fails <= MaxShownFails)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// output beat accepted: compare with the oldest expectation
		function void check_char(logic [7:0] ch, logic last);
			char_beat_t want;
			if (pending_chars.size() == 0) begin
				note_fail($sformatf("unexpected beat: char %02h last %0b", ch, last));
			end else begin
				want = pending_chars.pop_front();
				if (ch !== want.ch || last !== want.last)
					note_fail($sformatf("beat mismatch: expected char %02h last %0b, got char %02h last %0b",
						want.ch, want.last, ch, last));
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction

		function void flag_leftovers();
			while (pending_chars.size() != 0) begin
				note_fail($sformatf("missing beat: char %02h", pending_chars[0].ch));
				void'(pending_chars.pop_front());
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       text_valid;
	logic       text_stall;
	logic [7:0] text_byte;
	logic       end_of_input;
	logic       char_valid;
	logic       char_stall;
	logic [7:0] out_char;
	logic       last_of_item;

	respace_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	int stuck_cycles;

	comment_strip_token_spacer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.end_of_input (end_of_input),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.out_char     (out_char),
		.last_of_item (last_of_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver stalls at the current rate
	always @(posedge clk) begin
		char_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// both channels: note inputs first, then check outputs
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall)
				sb.note_byte(text_byte, end_of_input);
			if (char_valid && !char_stall)
				sb.check_char(out_char, last_of_item);
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (char_valid && !char_stall))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= StuckLimit) begin
				$display("%0t: no beat for %0d cycles", $realtime, StuckLimit);
				$display("comment_strip_token_spacer_test failed");
				$finish;
			end
		end
	end

	// one text beat, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < tx_idle_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid   <= 1'b1;
		text_byte    <= b;
		end_of_input <= eoi;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		string      delims;
		logic [7:0] blanks[5];
		logic [7:0] b;
		logic       eoi;
		int         sent;
		int         bytes_in_line;
		int         pick;
		bit         eoi_ends;

		sb           = new();
		delims       = "+-*/=(){}[]%?:|&,;";
		blanks       = '{CharSp, CharTab, CharCr, CharVt, CharFf};
		stuck_cycles = 0;
		tx_idle_pct  = 30;
		rx_idle_pct  = 50;
		arst_n       <= 1'b0;
		text_valid   <= 1'b0;
		text_byte    <= CharSp;
		end_of_input <= 1'b0;
		char_stall   <= 1'b0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, each blank, delimiter pairs, comments, line ends
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte("+", 1'b0);      // token then delimiter
		send_byte(CharSp, 1'b0);
		send_byte("=", 1'b0);      // whitespace then delimiter holds a space
		send_byte("-", 1'b0);      // held space plus separator: two spaces
		send_byte(CharSlash, 1'b0); // slash inside a delimiter run
		send_byte(CharTab, 1'b0);
		send_byte("b", 1'b0);
		send_byte(CharVt, 1'b0);
		send_byte(CharFf, 1'b0);
		send_byte(CharCr, 1'b0);
		send_byte(CharSlash, 1'b0); // comment drops the rest
		send_byte("z", 1'b0);
		send_byte(CharNl, 1'b0);
		send_byte(CharNl, 1'b0);   // empty line gives nothing
		send_byte("q", 1'b0);
		send_byte(CharSp, 1'b0);
		send_byte("(", 1'b0);
		send_byte("*", 1'b1);      // four beats, line ends on this byte
		send_byte("k", 1'b1);
		send_byte(CharSlash, 1'b1); // comment-only line ends with no output
		send_byte("t", 1'b0);
		send_byte(CharSp, 1'b0);
		send_byte(CharNl, 1'b1);   // trailing space dropped at newline

		// hold the sender until the block has drained
		wait_drained();

		// random lines with random content
		sent = 0;
		while (sent < RandomItems) begin
			if (sent < RandomItems / 3) begin
				tx_idle_pct = 30;
				rx_idle_pct = 50;
			end else if (sent < 2 * RandomItems / 3) begin
				tx_idle_pct = 50;
				rx_idle_pct = 30;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			bytes_in_line = $urandom_range(0, 12);
			eoi_ends = (bytes_in_line != 0) && ($urandom_range(99) < 30);
			for (int i = 0; i < bytes_in_line; i++) begin
				pick = $urandom_range(99);
				if (pick < 35)
					b = 8'h61 + 8'($urandom_range(25));
				else if (pick < 45)
					b = 8'($urandom_range(128, 255));
				else if (pick < 60)
					b = blanks[$urandom_range(4)];
				else if (pick < 80)
					b = delims[$urandom_range(delims.len() - 1)];
				else if (pick < 84)
					b = CharSlash;
				else
					b = 8'($urandom_range(1, 255));
				eoi = (eoi_ends && i == bytes_in_line - 1) || ($urandom_range(99) < 2);
				send_byte(b, eoi);
				sent++;
			end
			if (!eoi_ends) begin
				send_byte(CharNl, 1'($urandom_range(1)));
				sent++;
			end
		end

		// drain, then wait quietly to catch stray beats
		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		sb.flag_leftovers();
		if (sb.fails == 0)
			$display("comment_strip_token_spacer_test passed");
		else
			$display("comment_strip_token_spacer_test failed");
		$finish;
	end

endmodule
